// ===== rtl/lbfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbfs_pkg - shared types, codes and microcode for the BAOAB Langevin step
// Holds the Q16.16 constants, the operation and operand codes and the
// instruction ROM that drives the shared arithmetic unit.
// ----------------------------------------------------------------------------
package lbfs_pkg;

    localparam int CFG_W      = 17;
    localparam int NOISE_W    = 21;
    localparam int DATA_W     = 32;
    localparam int SCR_DEPTH  = 32;
    localparam int PC_W       = 7;

    // configuration register indexes
    localparam logic [1:0] CFG_STEP  = 2'd0;
    localparam logic [1:0] CFG_DECAY = 2'd1;
    localparam logic [1:0] CFG_GAIN  = 2'd2;

    localparam logic [CFG_W-1:0] STEP_RST  = 17'd66;
    localparam logic [CFG_W-1:0] DECAY_RST = 17'd65438;
    localparam logic [CFG_W-1:0] GAIN_RST  = 17'd4393;
    localparam logic signed [DATA_W-1:0] POS_X_RST = -32'sd6554;

    // Q16.16 constants of the potential
    localparam logic signed [DATA_W-1:0] K_INV_D2  = 32'sd8359;
    localparam logic signed [DATA_W-1:0] K_SQRT_4P = 32'sd4145;
    localparam logic signed [DATA_W-1:0] K_LIN     = 32'sd1602;
    localparam logic signed [DATA_W-1:0] K_R2      = 32'sd4514775;
    localparam logic signed [DATA_W-1:0] K_SQRT_P  = 32'sd2072;
    localparam logic signed [DATA_W-1:0] K_XW      = 32'sd9830;
    localparam logic signed [DATA_W-1:0] K_Y1      = 32'sd6554;
    localparam logic signed [DATA_W-1:0] K_TWO     = 32'sd131072;
    localparam logic signed [DATA_W-1:0] K_PK      = 32'sd26214;
    localparam logic signed [DATA_W-1:0] K_G1      = 32'sd13107;
    localparam logic signed [DATA_W-1:0] K_G2      = 32'sd52429;
    localparam logic signed [DATA_W-1:0] K_ONE     = 32'sd65536;

    // operations of the shared unit
    localparam logic [2:0] OP_MUL   = 3'd0;   // product >> 16, rounded, saturated
    localparam logic [2:0] OP_MUL17 = 3'd1;   // product >> 17, rounded, saturated
    localparam logic [2:0] OP_ADD   = 3'd2;
    localparam logic [2:0] OP_SUB   = 3'd3;
    localparam logic [2:0] OP_NEG   = 3'd4;
    localparam logic [2:0] OP_M6N   = 3'd5;   // -6 * a, saturated
    localparam logic [2:0] OP_DIV   = 3'd6;   // switch value 1/(1+a)

    // operand codes: scratch slots below 32, named operands from 32 up
    localparam logic [5:0] S0  = 6'd0;
    localparam logic [5:0] S1  = 6'd1;
    localparam logic [5:0] S2  = 6'd2;
    localparam logic [5:0] S3  = 6'd3;
    localparam logic [5:0] S4  = 6'd4;
    localparam logic [5:0] S5  = 6'd5;
    localparam logic [5:0] S6  = 6'd6;
    localparam logic [5:0] S7  = 6'd7;
    localparam logic [5:0] S8  = 6'd8;
    localparam logic [5:0] S9  = 6'd9;
    localparam logic [5:0] S10 = 6'd10;
    localparam logic [5:0] S11 = 6'd11;
    localparam logic [5:0] S12 = 6'd12;
    localparam logic [5:0] S13 = 6'd13;
    localparam logic [5:0] S14 = 6'd14;
    localparam logic [5:0] S15 = 6'd15;
    localparam logic [5:0] S16 = 6'd16;
    localparam logic [5:0] S17 = 6'd17;
    localparam logic [5:0] R_PX    = 6'd32;
    localparam logic [5:0] R_MX    = 6'd33;
    localparam logic [5:0] R_PY    = 6'd34;
    localparam logic [5:0] R_MY    = 6'd35;
    localparam logic [5:0] R_STEP  = 6'd36;
    localparam logic [5:0] R_DECAY = 6'd37;
    localparam logic [5:0] R_GAIN  = 6'd38;
    localparam logic [5:0] R_NX    = 6'd39;
    localparam logic [5:0] R_NY    = 6'd40;
    localparam logic [5:0] C_INVD2 = 6'd41;
    localparam logic [5:0] C_S4P   = 6'd42;
    localparam logic [5:0] C_LIN   = 6'd43;
    localparam logic [5:0] C_R2    = 6'd44;
    localparam logic [5:0] C_SP    = 6'd45;
    localparam logic [5:0] C_XW    = 6'd46;
    localparam logic [5:0] C_Y1    = 6'd47;
    localparam logic [5:0] C_TWO   = 6'd48;
    localparam logic [5:0] C_PK    = 6'd49;
    localparam logic [5:0] C_G1    = 6'd50;
    localparam logic [5:0] C_G2    = 6'd51;
    localparam logic [5:0] C_ONE   = 6'd52;

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] dst;
        logic [5:0] sa;
        logic [5:0] sb;
        logic       last;
    } t_instr;

    function automatic t_instr mk(input logic [2:0] op, input logic [5:0] dst,
                                  input logic [5:0] sa, input logic [5:0] sb,
                                  input logic last);
        t_instr r;
        r.op   = op;
        r.dst  = dst;
        r.sa   = sa;
        r.sb   = sb;
        r.last = last;
        return r;
    endfunction

    // force at (PX, PY): fx lands in S16, fy in S17
    function automatic t_instr force_instr(input logic [5:0] idx);
        t_instr r;
        case (idx)
            6'd0:  r = mk(OP_MUL, S0,  R_PX,  R_PX,    1'b0);
            6'd1:  r = mk(OP_MUL, S1,  R_PY,  R_PY,    1'b0);
            6'd2:  r = mk(OP_MUL, S2,  S0,    C_INVD2, 1'b0);
            6'd3:  r = mk(OP_MUL, S3,  S2,    S2,      1'b0);
            6'd4:  r = mk(OP_MUL, S4,  S3,    S2,      1'b0);
            6'd5:  r = mk(OP_DIV, S5,  S4,    S4,      1'b0);
            6'd6:  r = mk(OP_SUB, S6,  C_ONE, S5,      1'b0);
            6'd7:  r = mk(OP_MUL, S7,  R_PX,  C_INVD2, 1'b0);
            6'd8:  r = mk(OP_MUL, S8,  S3,    S7,      1'b0);
            6'd9:  r = mk(OP_MUL, S9,  S5,    S5,      1'b0);
            6'd10: r = mk(OP_MUL, S8,  S8,    S9,      1'b0);
            6'd11: r = mk(OP_M6N, S10, S8,    S8,      1'b0);
            6'd12: r = mk(OP_MUL, S11, R_PX,  C_S4P,   1'b0);
            6'd13: r = mk(OP_MUL, S11, S11,   S11,     1'b0);
            6'd14: r = mk(OP_ADD, S11, S11,   C_LIN,   1'b0);
            6'd15: r = mk(OP_MUL, S12, R_PX,  S11,     1'b0);
            6'd16: r = mk(OP_SUB, S13, S0,    C_R2,    1'b0);
            6'd17: r = mk(OP_MUL, S13, S13,   C_SP,    1'b0);
            6'd18: r = mk(OP_MUL, S13, S13,   S13,     1'b0);
            6'd19: r = mk(OP_MUL, S14, S0,    C_XW,    1'b0);
            6'd20: r = mk(OP_ADD, S14, S13,   S14,     1'b0);
            6'd21: r = mk(OP_MUL, S15, S1,    C_Y1,    1'b0);
            6'd22: r = mk(OP_ADD, S14, S14,   S15,     1'b0);
            6'd23: r = mk(OP_MUL, S15, S1,    C_PK,    1'b0);
            6'd24: r = mk(OP_ADD, S15, C_TWO, S15,     1'b0);
            6'd25: r = mk(OP_SUB, S15, S15,   S14,     1'b0);
            6'd26: r = mk(OP_MUL, S12, S12,   S6,      1'b0);
            6'd27: r = mk(OP_MUL, S10, S10,   S15,     1'b0);
            6'd28: r = mk(OP_ADD, S12, S12,   S10,     1'b0);
            6'd29: r = mk(OP_MUL, S7,  R_PY,  C_G1,    1'b0);
            6'd30: r = mk(OP_MUL, S7,  S7,    S6,      1'b0);
            6'd31: r = mk(OP_MUL, S8,  R_PY,  C_G2,    1'b0);
            6'd32: r = mk(OP_MUL, S8,  S5,    S8,      1'b0);
            6'd33: r = mk(OP_ADD, S7,  S7,    S8,      1'b0);
            6'd34: r = mk(OP_NEG, S16, S12,   S12,     1'b0);
            default: r = mk(OP_NEG, S17, S7,  S7,      1'b0);
        endcase
        return r;
    endfunction

    localparam logic [PC_W-1:0] PC_MID    = 7'd36;
    localparam logic [PC_W-1:0] PC_FORCE2 = 7'd54;
    localparam logic [PC_W-1:0] PC_KICK2  = 7'd90;

    // whole step: force, kick, drift, O update, drift, force, kick
    function automatic t_instr rom(input logic [PC_W-1:0] pc);
        t_instr   r;
        logic [PC_W-1:0] off;
        off = 7'd0;
        if (pc < PC_MID) begin
            r = force_instr(pc[5:0]);
        end else if (pc < PC_FORCE2) begin
            off = pc - PC_MID;
            case (off)
                7'd0:  r = mk(OP_MUL17, S0,   R_STEP,  S16,  1'b0);
                7'd1:  r = mk(OP_ADD,   R_MX, R_MX,    S0,   1'b0);
                7'd2:  r = mk(OP_MUL17, S0,   R_STEP,  S17,  1'b0);
                7'd3:  r = mk(OP_ADD,   R_MY, R_MY,    S0,   1'b0);
                7'd4:  r = mk(OP_MUL17, S0,   R_STEP,  R_MX, 1'b0);
                7'd5:  r = mk(OP_ADD,   R_PX, R_PX,    S0,   1'b0);
                7'd6:  r = mk(OP_MUL17, S0,   R_STEP,  R_MY, 1'b0);
                7'd7:  r = mk(OP_ADD,   R_PY, R_PY,    S0,   1'b0);
                7'd8:  r = mk(OP_MUL,   S0,   R_DECAY, R_MX, 1'b0);
                7'd9:  r = mk(OP_MUL,   S1,   R_GAIN,  R_NX, 1'b0);
                7'd10: r = mk(OP_ADD,   R_MX, S0,      S1,   1'b0);
                7'd11: r = mk(OP_MUL,   S0,   R_DECAY, R_MY, 1'b0);
                7'd12: r = mk(OP_MUL,   S1,   R_GAIN,  R_NY, 1'b0);
                7'd13: r = mk(OP_ADD,   R_MY, S0,      S1,   1'b0);
                7'd14: r = mk(OP_MUL17, S0,   R_STEP,  R_MX, 1'b0);
                7'd15: r = mk(OP_ADD,   R_PX, R_PX,    S0,   1'b0);
                7'd16: r = mk(OP_MUL17, S0,   R_STEP,  R_MY, 1'b0);
                default: r = mk(OP_ADD, R_PY, R_PY,    S0,   1'b0);
            endcase
        end else if (pc < PC_KICK2) begin
            off = pc - PC_FORCE2;
            r = force_instr(off[5:0]);
        end else begin
            off = pc - PC_KICK2;
            case (off)
                7'd0:  r = mk(OP_MUL17, S0,   R_STEP, S16, 1'b0);
                7'd1:  r = mk(OP_ADD,   R_MX, R_MX,   S0,  1'b0);
                7'd2:  r = mk(OP_MUL17, S0,   R_STEP, S17, 1'b0);
                default: r = mk(OP_ADD, R_MY, R_MY,   S0,  1'b1);
            endcase
        end
        return r;
    endfunction

endpackage

// ===== rtl/lbfs_ram.sv =====
// ----------------------------------------------------------------------------
// lbfs_ram - generic scratch RAM
// One write port and two registered read ports.
// ----------------------------------------------------------------------------
module lbfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and read, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== rtl/lbfs_div.sv =====
// ----------------------------------------------------------------------------
// lbfs_div - switch value divider
// Computes round(2^32 / (2^16 + t3)) in Q16.16, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lbfs_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_t3,
    output logic        o_busy,
    output logic [31:0] o_quot
);
    import lbfs_pkg::*;

    localparam int NUM_W = 35;

    logic [NUM_W-1:0] r_num;
    logic [32:0]      r_den;
    logic [32:0]      r_rem;
    logic [NUM_W-1:0] r_q;
    logic [5:0]       r_cnt;
    logic             r_busy;

    logic [32:0] den;
    logic [33:0] rem_sh;
    logic        ge;
    logic [33:0] rem_sub;

    assign den     = 33'(K_ONE) + {1'b0, i_t3};
    assign rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    // sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'(NUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // restoring division, numerator carries the rounding half
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= (NUM_W'(1) << 32) + NUM_W'(den >> 1);
            r_den <= den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= ge ? rem_sub[32:0] : rem_sh[32:0];
            r_q   <= {r_q[NUM_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q[31:0];

endmodule

// ===== rtl/lbfs_alu.sv =====
// ----------------------------------------------------------------------------
// lbfs_alu - shared multiply and saturating add unit
// Operands are captured with the product; rounding and saturation
// follow from the registered values.
// ----------------------------------------------------------------------------
module lbfs_alu (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic [2:0]         i_op,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [31:0] o_res
);
    import lbfs_pkg::*;

    logic [63:0]        r_prod;
    logic               r_neg;
    logic               r_sh17;
    logic               r_mul;
    logic signed [34:0] r_wide;

    logic [31:0]        ua;
    logic [31:0]        ub;
    logic signed [34:0] a35;
    logic signed [34:0] b35;
    logic signed [34:0] n_wide;
    logic [64:0]        rnd;
    logic [64:0]        mag;
    logic signed [31:0] mul_res;
    logic signed [31:0] lin_res;

    assign ua  = i_a[31] ? 32'(-i_a) : 32'(i_a);
    assign ub  = i_b[31] ? 32'(-i_b) : 32'(i_b);
    assign a35 = {{3{i_a[31]}}, i_a};
    assign b35 = {{3{i_b[31]}}, i_b};

    // select the linear result
    always_comb begin
        case (i_op)
            OP_ADD:  n_wide = a35 + b35;
            OP_SUB:  n_wide = a35 - b35;
            OP_NEG:  n_wide = -a35;
            OP_M6N:  n_wide = -((a35 <<< 2) + (a35 <<< 1));
            default: n_wide = a35;
        endcase
    end

    // capture product and sum
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= ua * ub;
            r_neg  <= i_a[31] ^ i_b[31];
            r_sh17 <= (i_op == OP_MUL17);
            r_mul  <= (i_op == OP_MUL) || (i_op == OP_MUL17);
            r_wide <= n_wide;
        end
    end

    // round half away from zero, then saturate
    assign rnd = {1'b0, r_prod} + (r_sh17 ? 65'h10000 : 65'h8000);
    assign mag = r_sh17 ? (rnd >> 17) : (rnd >> 16);

    always_comb begin
        if (r_neg) begin
            mul_res = (mag > 65'h80000000) ? 32'sh80000000 : 32'(-mag[31:0]);
        end else begin
            mul_res = (mag > 65'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(mag[31:0]);
        end
        if (r_wide > 35'sh7FFFFFFF) begin
            lin_res = 32'sh7FFFFFFF;
        end else if (r_wide < -35'sh80000000) begin
            lin_res = 32'sh80000000;
        end else begin
            lin_res = r_wide[31:0];
        end
    end

    assign o_res = r_mul ? mul_res : lin_res;

endmodule

// ===== rtl/langevin_baoab_fixed_step.sv =====
// ----------------------------------------------------------------------------
// langevin_baoab_fixed_step - one BAOAB Langevin step per request
// Advances a 2-D particle in a switched double-well potential, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one request carries two standard-normal samples
//   (noise_x, noise_y). Master stream: one result per request with the
//   new position and momentum of the particle.
//   Configuration: write step_size (0), decay (1), noise_gain (2) through
//   i_cfg_we / i_cfg_addr / i_cfg_wdata while the block is idle.
//   Timing: the 94 microcode instructions run in order on one shared
//   multiply/add unit, each through issue, execute and write-back, and
//   two of them also wait on a bit-serial divider. A new request is
//   accepted only once the previous one has run through the program.
//   o_s_tready is high only while the sequencer is idle; a finished
//   result waits in the output register, so a new request is accepted
//   while the receiver stalls, and its result holds until the previous
//   one is taken.
//   Reset: position (-0.1, 0), momentum zero, registers to defaults,
//   output empty. Scratch RAM needs no clearing.
// ----------------------------------------------------------------------------
module langevin_baoab_fixed_step (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [47:0]                     i_s_tdata,  // noise_x[20:0], noise_y[41:21]
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [127:0]                    o_m_tdata,  // pos_x, mom_x, pos_y, mom_y
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_addr,
    input  logic [lbfs_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import lbfs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_DIVW  = 3'd3;
    localparam logic [2:0] ST_WB    = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam int SCR_AW = $clog2(SCR_DEPTH);

    logic [2:0]             r_state, n_state;
    logic [PC_W-1:0]        r_pc, n_pc;
    logic signed [31:0]     r_px, r_mx, r_py, r_my;
    logic [CFG_W-1:0]       r_step, r_decay, r_gain;
    logic [NOISE_W-1:0]     r_nx, r_ny;
    logic                   r_ovalid;
    logic [127:0]           r_out;

    t_instr                 instr;
    logic signed [31:0]     opa, opb, wb_val, alu_res;
    logic [31:0]            ram_a, ram_b, div_q;
    logic                   div_busy, s_acc, ram_we, alu_load, div_start;

    assign instr = rom(r_pc);
    assign s_acc = i_s_tvalid && o_s_tready;

    // operand select
    function automatic logic signed [31:0] pick(input logic [5:0] code,
                                                input logic [31:0] ram_q);
        logic signed [31:0] v;
        v = 32'sd0;
        if (!code[5]) begin
            v = ram_q;
        end else begin
            case (code)
                R_PX:    v = r_px;
                R_MX:    v = r_mx;
                R_PY:    v = r_py;
                R_MY:    v = r_my;
                R_STEP:  v = 32'(r_step);
                R_DECAY: v = 32'(r_decay);
                R_GAIN:  v = 32'(r_gain);
                R_NX:    v = {{(32-NOISE_W){r_nx[NOISE_W-1]}}, r_nx};
                R_NY:    v = {{(32-NOISE_W){r_ny[NOISE_W-1]}}, r_ny};
                C_INVD2: v = K_INV_D2;
                C_S4P:   v = K_SQRT_4P;
                C_LIN:   v = K_LIN;
                C_R2:    v = K_R2;
                C_SP:    v = K_SQRT_P;
                C_XW:    v = K_XW;
                C_Y1:    v = K_Y1;
                C_TWO:   v = K_TWO;
                C_PK:    v = K_PK;
                C_G1:    v = K_G1;
                C_G2:    v = K_G2;
                C_ONE:   v = K_ONE;
                default: v = 32'sd0;
            endcase
        end
        return v;
    endfunction

    assign opa = pick(instr.sa, ram_a);
    assign opb = pick(instr.sb, ram_b);

    lbfs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SCR_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (instr.dst[SCR_AW-1:0]),
        .i_wdata   (wb_val),
        .i_raddr_a (instr.sa[SCR_AW-1:0]),
        .i_raddr_b (instr.sb[SCR_AW-1:0]),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    lbfs_alu u_alu (
        .i_clk  (i_clk),
        .i_load (alu_load),
        .i_op   (instr.op),
        .i_a    (opa),
        .i_b    (opb),
        .o_res  (alu_res)
    );

    lbfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_t3    (opa),
        .o_busy  (div_busy),
        .o_quot  (div_q)
    );

    assign alu_load  = (r_state == ST_EXEC);
    assign div_start = (r_state == ST_EXEC) && (instr.op == OP_DIV);
    assign wb_val    = (instr.op == OP_DIV) ? signed'(div_q) : alu_res;
    assign ram_we    = (r_state == ST_WB) && !instr.dst[5];

    // sequencer
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_state = ST_ISSUE;
                    n_pc    = '0;
                end
            end
            ST_ISSUE: n_state = ST_EXEC;
            ST_EXEC:  n_state = (instr.op == OP_DIV) ? ST_DIVW : ST_WB;
            ST_DIVW: begin
                if (!div_busy) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                if (instr.last) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_ISSUE;
                    n_pc    = r_pc + 7'd1;
                end
            end
            ST_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= STEP_RST;
            r_decay <= DECAY_RST;
            r_gain  <= GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_STEP:  r_step  <= i_cfg_wdata;
                CFG_DECAY: r_decay <= i_cfg_wdata;
                CFG_GAIN:  r_gain  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // hold the noise samples of the request
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_nx <= i_s_tdata[NOISE_W-1:0];
            r_ny <= i_s_tdata[2*NOISE_W-1:NOISE_W];
        end
    end

    // particle state write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= POS_X_RST;
            r_mx <= '0;
            r_py <= '0;
            r_my <= '0;
        end else if (r_state == ST_WB && instr.dst[5]) begin
            case (instr.dst)
                R_PX:    r_px <= wb_val;
                R_MX:    r_mx <= wb_val;
                R_PY:    r_py <= wb_val;
                R_MY:    r_my <= wb_val;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_DONE && (!r_ovalid || i_m_tready)) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && (!r_ovalid || i_m_tready)) begin
            r_out <= {r_my, r_py, r_mx, r_px};
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_out;

    // checks
    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> div_busy)
        else $error("divider did not start");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state == ST_ISSUE && r_pc == '0))
        else $error("request did not start the program");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WB && instr.last) |=> (r_state == ST_DONE))
        else $error("program end missed");

endmodule
